@@ rtl/ndsm_pkg.sv @@
// Shared types, constants and angle helpers for the nearest dihedral suite match core.
// No dependencies; imported by every module of the block.
package ndsm_pkg;

  localparam int NUM_ANGLES  = 7;
  localparam int ANGLE_W     = 11;
  localparam int NORM_W      = 9;
  localparam int DIFF_W      = 8;
  localparam int DIST_W      = 11;
  localparam int SLOT_W      = 6;
  localparam int CNT_W       = 7;
  localparam int DEF_TABLE_DEPTH = 64;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // register index as decoded from paddr[2]
  localparam logic REG_ENTRY_COUNT = 1'b0;

  // request kinds carried in in_tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [NORM_W-1:0]        FULL_TURN = 9'd360;
  localparam logic [NORM_W-1:0]        HALF_TURN = 9'd180;
  localparam logic signed [ANGLE_W:0]  TURN_S    = 12'sd360;
  localparam logic [DIST_W-1:0]        MAX_DIST  = 11'd1260;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [NUM_ANGLES-1:0][NORM_W-1:0] suite_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] best_slot;
    logic [DIST_W-1:0] best_distance;
  } scan_res_t;

  // Fold into 0..360; 11-bit inputs need at most three adds or two subtracts.
  function automatic logic [NORM_W-1:0] norm_angle(input angle_t raw);
    logic signed [ANGLE_W:0] t;
    t = {raw[ANGLE_W-1], raw};
    for (int i = 0; i < 3; i++) begin
      if (t < 0) t = t + TURN_S;
    end
    for (int i = 0; i < 2; i++) begin
      if (t > TURN_S) t = t - TURN_S;
    end
    return t[NORM_W-1:0];
  endfunction

  // Circular distance of two normalized angles, 0..180.
  function automatic logic [DIFF_W-1:0] circ_diff(input logic [NORM_W-1:0] x,
                                                  input logic [NORM_W-1:0] y);
    logic [NORM_W-1:0] d;
    if (x >= y) d = x - y;
    else        d = y - x;
    if (d > HALF_TURN) d = FULL_TURN - d;
    return d[DIFF_W-1:0];
  endfunction

endpackage

@@ rtl/ndsm_table.sv @@
// Suite table: one write port, one read port with registered read data.
// Depends on ndsm_pkg for the suite type.
module ndsm_table #(
  parameter int TABLE_DEPTH = ndsm_pkg::DEF_TABLE_DEPTH,
  parameter int AW          = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  ndsm_pkg::suite_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output ndsm_pkg::suite_t rd_data
);
  import ndsm_pkg::*;

  suite_t mem [TABLE_DEPTH];
  suite_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/ndsm_scan.sv @@
// Query scan: walks the table one entry a cycle, sums circular distances, keeps the minimum.
// Depends on ndsm_pkg; drives the read port of ndsm_table.
module ndsm_scan #(
  parameter int TABLE_DEPTH = ndsm_pkg::DEF_TABLE_DEPTH,
  parameter int AW          = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  ndsm_pkg::suite_t           query,
  input  logic [ndsm_pkg::CNT_W-1:0] cfg_count,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  input  ndsm_pkg::suite_t           rd_data,
  output logic                       done,
  output ndsm_pkg::scan_res_t        res
);
  import ndsm_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = (CW > CNT_W) ? CW : CNT_W;

  logic [SW-1:0] cnt_ext, cnt_sat;
  logic [CW-1:0] cnt_r, issue_r, issue_nxt;
  logic          busy_r, issuing_r;
  logic          v1_r, v2_r;
  logic [AW-1:0] idx1_r, idx2_r;
  logic [DIST_W-1:0] sum, sum2_r;
  suite_t        query_r;
  logic          found_r;
  logic [AW-1:0] best_idx_r;
  logic [DIST_W-1:0] best_d_r;
  logic [AW+SLOT_W-1:0] best_ext;

  // count above the table depth is clamped
  assign cnt_ext = SW'(cfg_count);
  assign cnt_sat = (cnt_ext > SW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : cnt_ext;

  assign issue_nxt = issue_r + 1'b1;
  assign rd_en     = issuing_r;
  assign rd_addr   = issue_r[AW-1:0];

  always_comb begin
    sum = '0;
    for (int k = 0; k < NUM_ANGLES; k++) begin
      sum = sum + DIST_W'(circ_diff(query_r[k], rd_data[k]));
    end
  end

  assign done = busy_r && !issuing_r && !v1_r && !v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      issuing_r <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      found_r   <= 1'b0;
    end else if (start) begin
      busy_r    <= 1'b1;
      issuing_r <= (cnt_sat != '0);
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      if (done) busy_r <= 1'b0;
      if (issuing_r && (issue_nxt == cnt_r)) issuing_r <= 1'b0;
      v1_r <= issuing_r;
      v2_r <= v1_r;
      if (v2_r) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      query_r    <= query;
      cnt_r      <= cnt_sat[CW-1:0];
      issue_r    <= '0;
      best_idx_r <= '0;
      best_d_r   <= '0;
    end else begin
      if (issuing_r) issue_r <= issue_nxt;
      // first compared slot always wins; later ones only when strictly smaller
      if (v2_r && (!found_r || sum2_r < best_d_r)) begin
        best_idx_r <= idx2_r;
        best_d_r   <= sum2_r;
      end
    end
    idx1_r <= issue_r[AW-1:0];
    idx2_r <= idx1_r;
    sum2_r <= sum;
  end

  assign best_ext          = {{SLOT_W{1'b0}}, best_idx_r};
  assign res.found         = found_r;
  assign res.best_slot     = best_ext[SLOT_W-1:0];
  assign res.best_distance = best_d_r;

  a_read_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> busy_r)
    else $error("table read outside a scan");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("scan did not start");

  a_pipe_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !start) |=> v2_r)
    else $error("read data lost between stages");

  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (done && res.found) |-> (res.best_distance <= MAX_DIST))
    else $error("distance above seven half turns");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !res.found) |-> (res.best_distance == '0 && res.best_slot == '0))
    else $error("empty scan with nonzero result");

endmodule

@@ rtl/nearest_dihedral_suite_match_core.sv @@
// Top level of the nearest dihedral suite match core: stream ports, APB register, control.
// Depends on ndsm_pkg, ndsm_table and ndsm_scan.
//
// Keeps up to TABLE_DEPTH reference suites of seven dihedral angles in a synchronous
// RAM. A load item (in_tuser = 0) normalizes its angles into 0..360 and writes one slot
// in the cycle it is accepted; it gives no result, and a slot not below TABLE_DEPTH is
// dropped. A query item (in_tuser = 1) reads slots 0..min(entry_count, TABLE_DEPTH)-1,
// one read per cycle through the single RAM read port, and returns the earliest slot with
// the smallest summed circular distance. A query occupies the core through its scan and
// the hand-off of its result to the output register, longer while an earlier result
// still waits there. The output register lets a new item be accepted while a result
// waits. entry_count is at byte address 0; the user must write it only while the core
// is idle, as the core does not enforce this. Slots must be loaded before any query
// scans them.
module nearest_dihedral_suite_match_core #(
  parameter int TABLE_DEPTH = ndsm_pkg::DEF_TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // slot[5:0], angle_delta_prev[16:6], angle_epsilon[27:17], angle_zeta[38:28],
  // angle_alpha[49:39], angle_beta[60:50], angle_gamma[71:61], angle_delta_next[82:72]
  input  logic [ndsm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [0:0]                       in_tuser,    // req_type[0]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // best_slot[5:0], best_distance[16:6]
  output logic [ndsm_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [0:0]                       out_tuser,   // found[0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ndsm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [ndsm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [ndsm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import ndsm_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] entry_count_r;
  logic             in_acc, cfg_wr;
  suite_t           in_norm;
  logic [SLOT_W-1:0] in_slot;
  logic [AW+SLOT_W-1:0] slot_ext;
  logic             slot_ok;
  logic             wr_en, rd_en, scan_start, scan_done;
  logic [AW-1:0]    rd_addr;
  suite_t           rd_data;
  scan_res_t        scan_res, out_res_r;
  logic             out_valid_r, out_load;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_ENTRY_COUNT) ? CFG_DATA_W'(entry_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_wr && cfg_paddr[2] == REG_ENTRY_COUNT) begin
      entry_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  // input side
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_slot   = in_tdata[SLOT_W-1:0];

  always_comb begin
    for (int k = 0; k < NUM_ANGLES; k++) begin
      in_norm[k] = norm_angle(in_tdata[SLOT_W + ANGLE_W*k +: ANGLE_W]);
    end
  end

  assign slot_ext   = {{AW{1'b0}}, in_slot};
  assign slot_ok    = (32'(in_slot) < 32'(TABLE_DEPTH));
  assign wr_en      = in_acc && (in_tuser[0] == REQ_LOAD) && slot_ok;
  assign scan_start = in_acc && (in_tuser[0] == REQ_QUERY);

  // loads and scans never overlap: a query is only taken in idle
  ndsm_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(slot_ext[AW-1:0]),
    .wr_data(in_norm),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ndsm_scan #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .query    (in_norm),
    .cfg_count(entry_count_r),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .done     (scan_done),
    .res      (scan_res)
  );

  // control
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (scan_start) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_done)  state_nxt = ST_OUT;
      ST_OUT:  if (out_load)   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_res_r <= scan_res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.found;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.best_distance, out_res_r.best_slot});

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for nearest_dihedral_suite_match_core: stream items in, matches out.
// Depends on ndsm_pkg and the core; a built-in predictor and directed expectations check every match result.
`timescale 1ns / 100ps

module tb_top;
  import ndsm_pkg::*;

  localparam int SETTLE_CYCLES = 80;   // longest scan plus pipeline, with margin
  localparam int PHASE_ITEMS   = 54;
  localparam int NO_MATCH_DIST = 10000;
  localparam logic [CFG_ADDR_W-1:0] ENTRY_COUNT_ADDR =
    CFG_ADDR_W'(4 * int'(REG_ENTRY_COUNT));

  typedef logic [NUM_ANGLES-1:0][ANGLE_W-1:0] dihedrals_t;
  typedef enum logic {STEP_ITEM, STEP_COUNT} step_kind_t;

  typedef struct packed {
    step_kind_t        kind;
    logic              req;
    logic [SLOT_W-1:0] slot;
    dihedrals_t        ang;
    logic              typed;
    scan_res_t         want;
    logic [CNT_W-1:0]  count;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // predictor state: normalized reference suites and the scan length register
  int        suite_ref [DEF_TABLE_DEPTH][NUM_ANGLES];
  int        scan_count = 0;
  scan_res_t expected_matches [$];
  plan_row_t directed_plan [$];
  int        mismatch_count = 0;
  int        snd_idle_pct = 21;
  int        rcv_idle_pct = 65;

  nearest_dihedral_suite_match_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int wrap_degrees(angle_t raw);
    int a;
    a = raw;
    while (a < 0) a += 360;
    while (a > 360) a -= 360;
    return a;
  endfunction

  function automatic int arc_degrees(int x, int y);
    int d;
    d = (x > y) ? x - y : y - x;
    if (d > 180) d = 360 - d;
    return d;
  endfunction

  function automatic scan_res_t nearest_suite(dihedrals_t ang);
    scan_res_t r;
    int        span;
    int        sum;
    int        best;
    int        q [NUM_ANGLES];
    r = '0;
    best = NO_MATCH_DIST;
    span = (scan_count > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : scan_count;
    for (int k = 0; k < NUM_ANGLES; k++) q[k] = wrap_degrees(angle_t'(ang[k]));
    for (int s = 0; s < span; s++) begin
      sum = 0;
      for (int k = 0; k < NUM_ANGLES; k++) sum += arc_degrees(q[k], suite_ref[s][k]);
      // strict compare keeps the earliest slot on ties
      if (sum < best) begin
        best = sum;
        r.found = 1'b1;
        r.best_slot = SLOT_W'(s);
        r.best_distance = DIST_W'(sum);
      end
    end
    return r;
  endfunction

  function automatic scan_res_t hit(int s, int d);
    scan_res_t r;
    r.found = 1'b1;
    r.best_slot = SLOT_W'(s);
    r.best_distance = DIST_W'(d);
    return r;
  endfunction

  function automatic dihedrals_t same_angle(int v);
    dihedrals_t a;
    for (int k = 0; k < NUM_ANGLES; k++) a[k] = ANGLE_W'(v);
    return a;
  endfunction

  function automatic angle_t rand_angle();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return angle_t'(int'($urandom_range(1079)) - 360);
    if (pick < 85) return angle_t'($urandom);
    case ($urandom_range(8))
      0:       return angle_t'(-1024);
      1:       return angle_t'(-360);
      2:       return angle_t'(-1);
      3:       return angle_t'(0);
      4:       return angle_t'(180);
      5:       return angle_t'(360);
      6:       return angle_t'(719);
      7:       return angle_t'(720);
      default: return angle_t'(1023);
    endcase
  endfunction

  function automatic dihedrals_t rand_suite();
    dihedrals_t a;
    for (int k = 0; k < NUM_ANGLES; k++) a[k] = rand_angle();
    return a;
  endfunction

  // angles of a stored suite, each moved by up to +/- spread degrees
  function automatic dihedrals_t suite_near(int s, int spread);
    dihedrals_t a;
    for (int k = 0; k < NUM_ANGLES; k++)
      a[k] = ANGLE_W'(suite_ref[s][k] + int'($urandom_range(2 * spread)) - spread);
    return a;
  endfunction

  function automatic void add_row(step_kind_t kind, logic req, int slot, dihedrals_t ang,
                                  logic typed, scan_res_t want, int count);
    plan_row_t row;
    row.kind = kind;
    row.req = req;
    row.slot = SLOT_W'(slot);
    row.ang = ang;
    row.typed = typed;
    row.want = want;
    row.count = CNT_W'(count);
    directed_plan = {directed_plan, row};
  endfunction

  function automatic void build_plan();
    dihedrals_t ext;
    dihedrals_t none;
    none = '0;
    ext[0] = ANGLE_W'(-1024);
    ext[1] = ANGLE_W'(1023);
    ext[2] = ANGLE_W'(360);
    ext[3] = ANGLE_W'(720);
    ext[4] = ANGLE_W'(-360);
    ext[5] = ANGLE_W'(719);
    ext[6] = ANGLE_W'(-1);
    // empty table scan right after reset
    add_row(STEP_ITEM, REQ_QUERY, 0, same_angle(-1024), 1'b1, '0, 0);
    add_row(STEP_ITEM, REQ_LOAD, 0, same_angle(0), 1'b0, '0, 0);
    add_row(STEP_ITEM, REQ_LOAD, 1, same_angle(180), 1'b0, '0, 0);
    add_row(STEP_ITEM, REQ_LOAD, 2, ext, 1'b0, '0, 0);
    add_row(STEP_ITEM, REQ_LOAD, 63, same_angle(-1), 1'b0, '0, 0);
    add_row(STEP_COUNT, REQ_LOAD, 0, none, 1'b0, '0, 1);
    add_row(STEP_ITEM, REQ_QUERY, 0, same_angle(0), 1'b1, hit(0, 0), 0);
    add_row(STEP_ITEM, REQ_QUERY, 0, same_angle(180), 1'b1, hit(0, 1260), 0);
    add_row(STEP_ITEM, REQ_QUERY, 0, same_angle(720), 1'b1, hit(0, 0), 0);
    add_row(STEP_COUNT, REQ_LOAD, 0, none, 1'b0, '0, 3);
    add_row(STEP_ITEM, REQ_QUERY, 0, same_angle(180), 1'b1, hit(1, 0), 0);
    // 360 and 0 are the same direction; slot field of a query is don't-care
    add_row(STEP_ITEM, REQ_QUERY, 63, same_angle(360), 1'b1, hit(0, 0), 0);
    add_row(STEP_ITEM, REQ_QUERY, 0, ext, 1'b0, '0, 0);
    add_row(STEP_ITEM, REQ_QUERY, 0, same_angle(90), 1'b1, hit(0, 630), 0);
    add_row(STEP_ITEM, REQ_QUERY, 0, same_angle(-180), 1'b1, hit(1, 0), 0);
    add_row(STEP_ITEM, REQ_QUERY, 42, same_angle(1023), 1'b0, '0, 0);
    // slot 3 duplicates slot 1: tie goes to the earlier slot
    add_row(STEP_ITEM, REQ_LOAD, 3, same_angle(540), 1'b0, '0, 0);
    add_row(STEP_COUNT, REQ_LOAD, 0, none, 1'b0, '0, 4);
    add_row(STEP_ITEM, REQ_QUERY, 0, same_angle(170), 1'b1, hit(1, 70), 0);
    add_row(STEP_ITEM, REQ_QUERY, 0, same_angle(0), 1'b1, hit(0, 0), 0);
  endfunction

  // offer one item, update the predictor when it is taken, then maybe idle
  task automatic send_item(input logic req, input logic [SLOT_W-1:0] slot,
                           input dihedrals_t ang, input logic typed, input scan_res_t want);
    int gap;
    in_tdata <= {{(IN_TDATA_W - SLOT_W - NUM_ANGLES * ANGLE_W){1'b0}}, ang, slot};
    in_tuser <= req;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (req == REQ_LOAD) begin
      for (int k = 0; k < NUM_ANGLES; k++) suite_ref[slot][k] = wrap_degrees(angle_t'(ang[k]));
    end else if (typed) begin
      expected_matches = {expected_matches, want};
    end else begin
      expected_matches = {expected_matches, nearest_suite(ang)};
    end
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_entry_count(input int value);
    wait_idle();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ENTRY_COUNT_ADDR;
    cfg_pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    scan_count = value & 'h7F;
  endtask

  always @(posedge clk) begin : match_check
    scan_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected match item, found=%0d slot=%0d distance=%0d", $time,
                 out_tuser[0], out_tdata[SLOT_W-1:0], out_tdata[SLOT_W +: DIST_W]);
        mismatch_count++;
      end else begin
        want = expected_matches.pop_front();
        if (out_tuser[0] !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, out_tuser[0]);
          mismatch_count++;
        end
        if (out_tdata[SLOT_W-1:0] !== want.best_slot) begin
          $display("%0t: best_slot expected %0d actual %0d", $time, want.best_slot,
                   out_tdata[SLOT_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[SLOT_W +: DIST_W] !== want.best_distance) begin
          $display("%0t: best_distance expected %0d actual %0d", $time, want.best_distance,
                   out_tdata[SLOT_W +: DIST_W]);
          mismatch_count++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  initial begin : stimulus
    dihedrals_t ang;
    int         c;
    int         pick;
    build_plan();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == STEP_COUNT) begin
        set_entry_count(directed_plan[i].count);
      end else begin
        send_item(directed_plan[i].req, directed_plan[i].slot, directed_plan[i].ang,
                  directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // fill the whole table so any scan length is legal from here on
    for (int s = 0; s < DEF_TABLE_DEPTH; s++) send_item(REQ_LOAD, SLOT_W'(s), rand_suite(), 1'b0, '0);

    for (int p = 0; p < 9; p++) begin
      case (p)
        0:       c = 127;
        1:       c = 0;
        2:       c = 64;
        3:       c = 1;
        4:       c = 65;
        5:       c = 64;
        6:       c = 127;
        default: c = $urandom_range(1, 127);
      endcase
      set_entry_count(c);
      if (p < 3) begin
        snd_idle_pct = 21;
        rcv_idle_pct = 65;
      end else if (p < 6) begin
        snd_idle_pct = 65;
        rcv_idle_pct = 21;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          // some loads copy another suite exactly to provoke ties
          ang = (pick < 4) ? suite_near($urandom_range(63), 0) : rand_suite();
          send_item(REQ_LOAD, SLOT_W'($urandom_range(63)), ang, 1'b0, '0);
        end else begin
          ang = (pick < 70) ? suite_near($urandom_range(63), 6) : rand_suite();
          send_item(REQ_QUERY, SLOT_W'($urandom_range(63)), ang, 1'b0, '0);
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
